/* hw/rtl/rdle_pkg.sv */
// Shared constants, command codes and controller-to-datapath types for the deque list engine.
`default_nettype none

package rdle_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int PTR_W      = $clog2(LIST_DEPTH + 1);
    localparam int VALUE_W    = 16;
    localparam int ACC_W      = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LIST  = 2'd1;
    localparam logic [1:0] CMD_PROG  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Strobes from the controller; at most one of the first four per cycle.
    typedef struct packed {
        logic clear;
        logic list_char;
        logic prog_char;
        logic read_req;
        logic load_out;
    } rdle_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/rdle_datapath.sv */
// Datapath: number parser, element store, head and tail pointers, flags and result register.
`default_nettype none

module rdle_datapath
    import rdle_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rdle_cmd_t          cmd,
    input  wire logic [7:0]         char_code,
    output logic [VALUE_W-1:0]      elem_value,
    output logic                    is_last,
    output logic                    list_empty,
    output logic                    error_flag
);

    logic [VALUE_W-1:0] store [LIST_DEPTH];

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic               reversed_reg, reversed_next;
    logic               error_reg, error_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               seen_reg, seen_next;

    // Response flags captured at read time, together with the store data.
    logic               rsp_ok_reg, rsp_last_reg, rsp_err_reg;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               is_digit, is_sep, not_empty, can_append, read_ok;
    logic [ACC_W-1:0]   acc_times_ten;
    logic [PTR_W-1:0]   tail_dec, rd_ptr, span;

    always_comb begin
        is_digit      = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        is_sep        = (char_code == CHAR_COMMA) || (char_code == CHAR_CLOSE);
        not_empty     = head_reg < tail_reg;
        can_append    = seen_reg && (tail_reg < PTR_W'(LIST_DEPTH));
        read_ok       = !error_reg && not_empty;
        tail_dec      = tail_reg - 1'b1;
        span          = tail_reg - head_reg;
        rd_ptr        = reversed_reg ? tail_dec : head_reg;
        acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + ACC_W'(char_code - CHAR_ZERO);
    end

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        reversed_next = reversed_reg;
        error_next    = error_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        if (cmd.clear) begin
            head_next     = '0;
            tail_next     = '0;
            reversed_next = 1'b0;
            error_next    = 1'b0;
            acc_next      = '0;
            seen_next     = 1'b0;
        end else if (cmd.list_char) begin
            if (is_digit) begin
                acc_next  = (acc_times_ten > ACC_W'(VALUE_MAX))
                          ? VALUE_MAX : acc_times_ten[VALUE_W-1:0];
                seen_next = 1'b1;
            end else if (is_sep) begin
                if (can_append) begin
                    tail_next = tail_reg + 1'b1;
                end
                acc_next  = '0;
                seen_next = 1'b0;
            end
        end else if (cmd.prog_char && !error_reg) begin
            if (char_code == CHAR_R) begin
                reversed_next = !reversed_reg;
            end else if (char_code == CHAR_D) begin
                if (!not_empty) begin
                    error_next = 1'b1;
                end else if (reversed_reg) begin
                    tail_next = tail_dec;
                end else begin
                    head_next = head_reg + 1'b1;
                end
            end
        end else if (cmd.read_req && read_ok) begin
            if (reversed_reg) begin
                tail_next = tail_dec;
            end else begin
                head_next = head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            reversed_reg <= 1'b0;
            error_reg    <= 1'b0;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            reversed_reg <= reversed_next;
            error_reg    <= error_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
        end
    end

    // Element store: one write port for parsed numbers, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.list_char && is_sep && can_append) begin
            store[tail_reg[ADDR_W-1:0]] <= acc_reg;
        end
        if (cmd.read_req) begin
            rd_data_reg  <= store[rd_ptr[ADDR_W-1:0]];
            rsp_ok_reg   <= read_ok;
            rsp_last_reg <= read_ok && (span == PTR_W'(1));
            rsp_err_reg  <= error_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            elem_value <= rsp_ok_reg ? rd_data_reg : '0;
            is_last    <= rsp_last_reg;
            list_empty <= !rsp_ok_reg;
            error_flag <= rsp_err_reg;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rdle_ctrl.sv */
// Controller: accepts words, decodes commands and sequences reads into the result register.
`default_nettype none

module rdle_ctrl
    import rdle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] command,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output rdle_cmd_t       cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd           = '0;
        cmd.clear     = accept && (command == CMD_CLEAR);
        cmd.list_char = accept && (command == CMD_LIST);
        cmd.prog_char = accept && (command == CMD_PROG);
        cmd.read_req  = accept && (command == CMD_READ);
        cmd.load_out  = (state_reg == ST_RESP) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                    end
                    if (cmd.read_req) begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/reversible_deque_list_engine.sv */
// Top level of the reversible deque list engine: controller, datapath and checks.
//
// Input words carry a command in s_tuser and a character in s_tdata. A clear command starts
// a new case; list characters such as "[12,7,300]" are parsed into decimal numbers that are
// appended to a 1024-entry store; program characters 'R' flip the reading direction and 'D'
// drop the current head element. Dropping from an empty list raises a sticky error that
// makes later program characters have no effect until the next clear.
// A read command produces exactly one output word: the next element in the current order on
// m_tdata (and removes it), m_tlast when it was the last one left, and m_tuser flags for an
// empty list and for the sticky error. No other command produces an output word.
// Clear, list and program words are accepted back to back. For a read, the store is read at
// the edge that accepts it; the controller then waits in its response state until the output
// register is free, loads it and raises m_tvalid. Further words are accepted while an earlier
// result waits in the output register, but every read holds s_tready low while the controller
// is in its response state, which lasts until m_tready frees a stalled output register.
// Reset (aresetn low at a clock edge) empties the list, clears the direction and error flags
// and drops any pending result; the store itself is not cleared, since only entries written
// after the latest clear are ever read.
`default_nettype none

module reversible_deque_list_engine
    import rdle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] elem_value
    output logic             m_tlast,   // is_last
    output logic [1:0]       m_tuser    // [0] list_empty, [1] error_flag
);

    rdle_cmd_t cmd;

    // The controller owns the handshakes; the datapath never sees valid or ready.
    rdle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the pointers, flags, store and the output payload register.
    rdle_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .char_code  (s_tdata),
        .elem_value (m_tdata),
        .is_last    (m_tlast),
        .list_empty (m_tuser[0]),
        .error_flag (m_tuser[1])
    );

`ifndef SYNTHESIS
    // A read word always blocks input on the following cycle while its result waits for the output register.
    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_READ) |=> !s_tready)
        else $error("read accepted without entering the response state");

    // An empty result carries a zero value and no last mark.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tlast))
        else $error("empty result with non-zero value or last mark");

    // While the error is set no element is ever returned.
    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("element returned while the error flag is set");
`endif

endmodule

`default_nettype wire

/* verif/tb_reversible_deque_list_engine.sv */
// Self-checking testbench for the reversible deque list engine, with its own predictor.
module tb_reversible_deque_list_engine;
    import rdle_pkg::*;

    localparam int QUIET_LIMIT = 2000;  // cycles with no word accepted on either side
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the pressure test

    // One expected result word of a read command.
    typedef struct packed {
        logic [15:0] value;
        logic        last;
        logic        empty;
        logic        err;
    } deque_read_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;      // [7:0] char_code
    logic [1:0]  s_tuser  = CMD_CLEAR;  // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;               // [15:0] elem_value
    logic        m_tlast;               // is_last
    logic [1:0]  m_tuser;               // [0] list_empty, [1] error_flag

    // Predicted deque state, kept in step with every accepted word.
    logic [15:0]      model_store [LIST_DEPTH];
    logic [PTR_W-1:0] front_ptr   = '0;
    logic [PTR_W-1:0] back_ptr    = '0;
    logic             dir_flipped = 1'b0;
    logic             drop_fault  = 1'b0;
    logic [15:0]      num_acc     = '0;
    logic             num_open    = 1'b0;

    deque_read_t pending_reads[$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;

    // Idling controls; the receiver ones are written with nonblocking assignments.
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned hold_ask     = 0;
    int unsigned hold_len     = 0;

    reversible_deque_list_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advances the predicted state by one accepted word and queues the result of a read.
    function automatic void apply_deque_word(input logic [1:0] cmd, input logic [7:0] ch);
        int unsigned grown;
        deque_read_t res;
        res = '{value: 16'h0000, last: 1'b0, empty: 1'b1, err: 1'b0};
        case (cmd)
            CMD_CLEAR: begin
                front_ptr   = '0;
                back_ptr    = '0;
                dir_flipped = 1'b0;
                drop_fault  = 1'b0;
                num_acc     = '0;
                num_open    = 1'b0;
            end
            CMD_LIST: begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    grown = int'(num_acc) * 10 + int'(ch - CHAR_ZERO);
                    num_acc  = (grown > VALUE_MAX) ? VALUE_MAX : 16'(grown);
                    num_open = 1'b1;
                end else if (ch == CHAR_COMMA || ch == CHAR_CLOSE) begin
                    // A number finished while the store is full is thrown away.
                    if (num_open && back_ptr < LIST_DEPTH) begin
                        model_store[back_ptr[ADDR_W-1:0]] = num_acc;
                        back_ptr++;
                    end
                    num_acc  = '0;
                    num_open = 1'b0;
                end
            end
            CMD_PROG: begin
                if (!drop_fault) begin
                    if (ch == CHAR_R) begin
                        dir_flipped = !dir_flipped;
                    end else if (ch == CHAR_D) begin
                        if (front_ptr < back_ptr) begin
                            if (dir_flipped) back_ptr--;
                            else front_ptr++;
                        end else begin
                            drop_fault = 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (!drop_fault && front_ptr < back_ptr) begin
                    res.last  = (back_ptr - front_ptr == 1);
                    res.empty = 1'b0;
                    if (dir_flipped) begin
                        back_ptr--;
                        res.value = model_store[back_ptr[ADDR_W-1:0]];
                    end else begin
                        res.value = model_store[front_ptr[ADDR_W-1:0]];
                        front_ptr++;
                    end
                end
                res.err = drop_fault;
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Offers one word, after a random gap when source idling is enabled, and waits until the block takes it.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        do @(posedge aclk); while (s_tready !== 1'b1);
        apply_deque_word(cmd, ch);
        words_sent++;
    endtask

    task automatic send_text(input logic [1:0] cmd, input string txt);
        for (int i = 0; i < txt.len(); i++) send_word(cmd, txt[i]);
    endtask

    task automatic send_reads(input int unsigned n);
        repeat (n) send_word(CMD_READ, 8'($urandom_range(0, 255)));
    endtask

    // The sender goes quiet until every outstanding read result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_read_word();
        deque_read_t want;
        if (pending_reads.size() == 0) begin
            report_mismatch("read result with none outstanding, elem_value", m_tdata, 0);
        end else begin
            want = pending_reads.pop_front();
            if (m_tdata !== want.value) report_mismatch("elem_value", m_tdata, want.value);
            if (m_tlast !== want.last) report_mismatch("is_last", m_tlast, want.last);
            if (m_tuser[0] !== want.empty) report_mismatch("list_empty", m_tuser[0], want.empty);
            if (m_tuser[1] !== want.err) report_mismatch("error_flag", m_tuser[1], want.err);
        end
    endtask

    // Receiver: checks each result word, then, when receiver idling is enabled, stalls for a random number of cycles.
    // A hold-off request from a test keeps m_tready low for a long stretch.
    always @(posedge aclk) begin : result_sink
        int unsigned sink_gap;
        int unsigned hold_left;
        int unsigned hold_seen;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap  = 0;
            hold_left = 0;
            hold_seen = hold_ask;
        end else begin
            if (m_tvalid && m_tready) begin
                check_read_word();
                sink_gap = sink_idle_en ? $urandom_range(0, 19) : 0;
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = hold_len;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge aclk) begin : stall_watch
        int unsigned quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_reversible_deque_list_engine: FAIL");
            $finish;
        end
    end

    // A read straight after reset sees an empty list and no error.
    task automatic test_reset_read();
        send_word(CMD_READ, 8'hFF);
        drain_results();
    endtask

    // Saturation, an empty slot, an ignored letter and an empty list.
    task automatic test_number_parsing();
        send_word(CMD_CLEAR, 8'h00);
        send_text(CMD_LIST, "[65535,70000,,7x]");
        send_reads(4);
        send_text(CMD_LIST, "[]");
        send_reads(1);
        drain_results();
    endtask

    // Reverse, drop, an unknown program letter, and a number added after the program.
    task automatic test_program_edits();
        send_word(CMD_CLEAR, 8'h00);
        send_text(CMD_LIST, "[1,2,3]");
        send_text(CMD_PROG, "RDq");
        send_reads(1);
        send_text(CMD_PROG, "R");
        send_text(CMD_LIST, "4]");
        send_reads(4);
        drain_results();
    endtask

    // A drop on an empty list sets the error, which later program words cannot clear.
    task automatic test_drop_error();
        send_word(CMD_CLEAR, 8'h00);
        send_text(CMD_LIST, "[9]");
        send_text(CMD_PROG, "DDR");
        send_reads(1);
        send_word(CMD_CLEAR, 8'h00);
        send_reads(1);
        drain_results();
    endtask

    // Fills the store past its depth; the surplus numbers must be dropped.
    task automatic test_store_full();
        src_idle_en = 1'b0;
        send_word(CMD_CLEAR, 8'h00);
        send_word(CMD_LIST, CHAR_OPEN);
        for (int i = 0; i < LIST_DEPTH + 6; i++) begin
            send_word(CMD_LIST, CHAR_ZERO + 8'(i % 10));
            send_word(CMD_LIST, CHAR_COMMA);
        end
        send_word(CMD_LIST, CHAR_CLOSE);
        send_reads(2);
        send_text(CMD_PROG, "R");
        send_reads(2);
        send_text(CMD_PROG, "D");
        send_text(CMD_LIST, "65535]");
        send_reads(3);
        src_idle_en = 1'b1;
        drain_results();
    endtask

    // The receiver holds off for a long stretch while reads keep coming, so the
    // block has to stall its input; the sender then waits for every result.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        hold_len <= HOLD_CYCLES;
        hold_ask <= hold_ask + 1;
        send_word(CMD_CLEAR, 8'h00);
        send_text(CMD_LIST, "[11,22,33,44]");
        send_reads(12);
        drain_results();
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
    endtask

    // Mostly well-formed cases with random content, mixed with stray words.
    task automatic test_random_cases();
        int unsigned stop_at;
        int unsigned n_num;
        int unsigned n_dig;
        int unsigned pick;
        stop_at = words_sent + 900;
        while (words_sent < stop_at) begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) != 0) send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) != 0) send_word(CMD_LIST, CHAR_OPEN);
            n_num = $urandom_range(0, 8);
            for (int k = 0; k < n_num; k++) begin
                // Mostly short numbers; now and then long ones that saturate or none at all.
                n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3);
                repeat (n_dig) send_word(CMD_LIST, CHAR_ZERO + 8'($urandom_range(0, 9)));
                if (k + 1 < n_num) send_word(CMD_LIST, CHAR_COMMA);
            end
            send_word(CMD_LIST, CHAR_CLOSE);
            repeat ($urandom_range(0, 8)) begin
                pick = $urandom_range(0, 5);
                if (pick < 2) send_word(CMD_PROG, CHAR_R);
                else if (pick < 5) send_word(CMD_PROG, CHAR_D);
                else send_word(CMD_PROG, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) begin
                send_word(CMD_LIST, CHAR_ZERO + 8'($urandom_range(0, 9)));
                send_word(CMD_LIST, CHAR_CLOSE);
            end
            send_reads($urandom_range(0, n_num + 2));
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_read();
        test_number_parsing();
        test_program_edits();
        test_drop_error();
        test_store_full();
        test_backpressure();
        test_random_cases();
        drain_results();
        repeat (10) @(posedge aclk);
        if (pending_reads.size() != 0) begin
            report_mismatch("read results never delivered", 0, pending_reads.size());
        end
        if (mismatches == 0) begin
            $display("tb_reversible_deque_list_engine: PASS");
        end else begin
            $display("tb_reversible_deque_list_engine: FAIL");
        end
        $finish;
    end

endmodule
